### sv/assert_macros.svh
// Assertion helpers shared by the modules that carry checks.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression must never be true.
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

### sv/conv3_pkg.sv
// ---------------------------------------------------------------------------
// conv3_pkg: shared types and constants of the 3x3 fp16 convolution block
// Field widths, command and register codes, queue entry and status structs.
// ---------------------------------------------------------------------------
package conv3_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAN_W     = 4;
    localparam int POS_W      = 6;
    localparam int TAP_W      = 4;
    localparam int HALF_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int ICH_W      = 5;
    localparam int OCH_W      = 5;
    localparam int DIM_W      = 7;

    localparam int TAPS  = 9;
    localparam int KSIZE = 3;
    localparam int PAD   = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HALF_W-1:0] HALF_ONE  = 16'h3C00;
    localparam logic [HALF_W-1:0] HALF_QNAN = 16'h7E00;
    localparam logic [HALF_W-1:0] HALF_INF  = 16'h7C00;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_WEIGHT = 2'd0,
        CMD_WR_BIAS   = 2'd1,
        CMD_WR_PIXEL  = 2'd2,
        CMD_COMPUTE   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_CHANNELS  = 3'd0,
        CFG_OUT_CHANNELS = 3'd1,
        CFG_HEIGHT       = 3'd2,
        CFG_WIDTH        = 3'd3,
        CFG_BIAS_ENABLE  = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_WR_WEIGHT,
        KIND_WR_BIAS,
        KIND_WR_PIXEL,
        KIND_COMPUTE,
        KIND_RANGE_ERR
    } item_kind_t;

    typedef enum logic [1:0] {
        FP_ZERO,
        FP_NORM,
        FP_INF,
        FP_NAN
    } fp_class_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [CHAN_W-1:0] out_chan;
        logic [CHAN_W-1:0] in_chan;
        logic [POS_W-1:0]  row_index;
        logic [POS_W-1:0]  col_index;
        logic [TAP_W-1:0]  tap;
        logic [HALF_W-1:0] data_word;
    } q_entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } q_status_t;

    typedef struct packed {
        logic [ICH_W-1:0] nic;
        logic [DIM_W-1:0] nh;
        logic [DIM_W-1:0] nw;
        logic             bias_en;
    } size_t;

endpackage

### sv/conv3_if.sv
// ---------------------------------------------------------------------------
// conv3 channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// ---------------------------------------------------------------------------
interface conv3_in_if import conv3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] out_chan;
    logic [CHAN_W-1:0] in_chan;
    logic [POS_W-1:0]  row_index;
    logic [POS_W-1:0]  col_index;
    logic [TAP_W-1:0]  tap;
    logic [HALF_W-1:0] data_word;

    modport source (output valid, cmd, out_chan, in_chan, row_index, col_index, tap,
                    data_word, input ready);
    modport sink (input valid, cmd, out_chan, in_chan, row_index, col_index, tap,
                  data_word, output ready);
endinterface

interface conv3_out_if import conv3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] out_value;
    logic              range_error;

    modport source (output valid, out_value, range_error, input ready);
    modport sink (input valid, out_value, range_error, output ready);
endinterface

interface conv3_cfg_if import conv3_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/conv2d_3x3_same_fp16_top.sv
// ---------------------------------------------------------------------------
// conv2d_3x3_same_fp16_top: 3x3 same-size convolution over fp16 feature maps
// Front classifier, item queue and a sequential fp32 multiply-add back end.
// ---------------------------------------------------------------------------
//
//  Channel  Role   Carries
//  -------  -----  ------------------------------------------------------------
//  item     sink   cmd, out_chan, in_chan, row_index, col_index, tap, data_word
//  result   source out_value, range_error (one per compute transaction)
//  cfg      sink   index, data (register writes, always ready)
//
// A store write or an out-of-range compute leaves the queue while the back stays idle.
// A compute transaction runs the single shared multiply, normalize, align, add,
// normalize and round sequence once per in-bounds product, and once more for
// the bias when it is enabled. A product that meets a zero, infinite or NaN
// operand skips the adder.
// Reset clears control state only; the stores hold undefined data until written.
// The item channel stalls only when the two-entry queue is full, so items keep
// arriving while a result waits on a stalled result channel.
//
module conv2d_3x3_same_fp16_top import conv3_pkg::*;
#(
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    conv3_in_if.sink    item,
    conv3_out_if.source result,
    conv3_cfg_if.sink   cfg
);

    `include "assert_macros.svh"

    // Queue traffic between the front and the back.
    q_entry_t  push_data;
    q_entry_t  head;
    logic      push;
    logic      pop;
    q_status_t q_stat;
    // Saturated sizes, bias mode; user keeps stable in compute transactions.
    size_t     sizes;

    // The front accepts every item transaction it has queue room for and drops
    // writes that fall outside the stores.
    conv3_front #(
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .q_stat    (q_stat),
        .sizes     (sizes)
    );

    conv3_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_stat)
    );

    // The back owns the stores and the accumulator and drives the result
    // register.
    conv3_back #(
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .sizes  (sizes),
        .result (result)
    );

    // The queue is never written when full nor read when empty.
    `ASSERT_IMPLIES(a_no_push_full, push, !q_stat.full)
    `ASSERT_IMPLIES(a_no_pop_empty, pop, !q_stat.empty)
    // A range error result always carries a zero value.
    `ASSERT_IMPLIES(a_err_zero, result.valid && result.range_error, result.out_value == 16'd0)
    `ASSERT_NEVER(a_count_bound, q_stat.count > QCNT_W'(QUEUE_DEPTH))

endmodule

### sv/conv3_fifo.sv
// ---------------------------------------------------------------------------
// conv3_fifo: short queue between the front and the back
// Holds classified items so that the two sides stall independently.
// ---------------------------------------------------------------------------
module conv3_fifo import conv3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_data,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### sv/conv3_front.sv
// ---------------------------------------------------------------------------
// conv3_front: input acceptance, classification and configuration registers
// Drops writes outside the stores and flags compute indexes out of range.
// ---------------------------------------------------------------------------
module conv3_front import conv3_pkg::*;
#(
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    conv3_in_if.sink   item,
    conv3_cfg_if.sink  cfg,
    output logic       push,
    output q_entry_t   push_data,
    input  q_status_t  q_stat,
    output size_t      sizes
);

    logic [ICH_W-1:0] in_ch_reg;
    logic [OCH_W-1:0] out_ch_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] width_reg;
    logic             bias_en_reg;

    logic [OCH_W-1:0] noc;
    logic             range_bad;
    logic             keep;
    item_kind_t       kind;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg   <= ICH_W'(1);
            out_ch_reg  <= OCH_W'(1);
            height_reg  <= DIM_W'(1);
            width_reg   <= DIM_W'(1);
            bias_en_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_IN_CHANNELS:  in_ch_reg   <= cfg.data[ICH_W-1:0];
                CFG_OUT_CHANNELS: out_ch_reg  <= cfg.data[OCH_W-1:0];
                CFG_HEIGHT:       height_reg  <= cfg.data[DIM_W-1:0];
                CFG_WIDTH:        width_reg   <= cfg.data[DIM_W-1:0];
                CFG_BIAS_ENABLE:  bias_en_reg <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    // Sizes above the store limits saturate to the limits.
    assign sizes.nic = (32'(in_ch_reg) > MAX_IN_CH) ? ICH_W'(MAX_IN_CH) : in_ch_reg;
    assign sizes.nh  = (32'(height_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : height_reg;
    assign sizes.nw  = (32'(width_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : width_reg;
    assign sizes.bias_en = bias_en_reg;
    assign noc = (32'(out_ch_reg) > MAX_OUT_CH) ? OCH_W'(MAX_OUT_CH) : out_ch_reg;

    assign range_bad = (OCH_W'(item.out_chan) >= noc) ||
                       (DIM_W'(item.row_index) >= sizes.nh) ||
                       (DIM_W'(item.col_index) >= sizes.nw);

    always_comb
    begin
        keep = 1'b1;
        kind = KIND_COMPUTE;
        unique case (cmd_t'(item.cmd))
            CMD_WR_WEIGHT:
            begin
                kind = KIND_WR_WEIGHT;
                keep = (32'(item.out_chan) < MAX_OUT_CH) && (32'(item.in_chan) < MAX_IN_CH)
                       && (32'(item.tap) < TAPS);
            end
            CMD_WR_BIAS:
            begin
                kind = KIND_WR_BIAS;
                keep = (32'(item.out_chan) < MAX_OUT_CH);
            end
            CMD_WR_PIXEL:
            begin
                kind = KIND_WR_PIXEL;
                keep = (32'(item.in_chan) < MAX_IN_CH) && (32'(item.row_index) < MAX_ROWS)
                       && (32'(item.col_index) < MAX_COLS);
            end
            CMD_COMPUTE:
                kind = range_bad ? KIND_RANGE_ERR : KIND_COMPUTE;
            default:
                keep = 1'b0;
        endcase
    end

    assign item.ready = !q_stat.full;
    assign push       = item.valid && !q_stat.full && keep;

    assign push_data.kind      = kind;
    assign push_data.out_chan  = item.out_chan;
    assign push_data.in_chan   = item.in_chan;
    assign push_data.row_index = item.row_index;
    assign push_data.col_index = item.col_index;
    assign push_data.tap       = item.tap;
    assign push_data.data_word = item.data_word;

endmodule

### sv/conv3_back.sv
// ---------------------------------------------------------------------------
// conv3_back: stores and the sequential fp32 multiply-add engine
// Carries out store writes and computes one output pixel per compute item.
// ---------------------------------------------------------------------------
module conv3_back import conv3_pkg::*;
#(
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_entry_t    head,
    input  q_status_t   q_stat,
    output logic        pop,
    input  size_t       sizes,
    conv3_out_if.source result
);

    localparam int WDEPTH = MAX_OUT_CH * MAX_IN_CH * TAPS;
    localparam int PDEPTH = MAX_IN_CH * MAX_ROWS * MAX_COLS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int BAW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    // Biased fp32 exponent of a half product: 150 - 50 - 2 with the shift added back.
    localparam int PROD_EXP_OFFSET = 98;

    typedef enum logic [3:0] {
        B_IDLE, B_BIAS, B_ADDR, B_MUL, B_PNORM, B_ALIGN, B_ADD, B_NORM, B_ROUND, B_FINAL
    } bstate_t;

    typedef struct packed {
        logic      sign;
        logic [4:0] exp;
        logic [10:0] sig;
        fp_class_t cls;
    } half_dec_t;

    function automatic half_dec_t half_decode(logic [HALF_W-1:0] h);
        half_dec_t d;
        d.sign = h[15];
        d.exp  = h[14:10];
        d.sig  = {1'b1, h[9:0]};
        d.cls  = FP_NORM;
        if (h[14:10] == 5'h1F)
        begin
            d.sig = 11'd0;
            d.cls = (h[9:0] != 10'd0) ? FP_NAN : FP_INF;
        end
        else if (h[14:10] == 5'd0)
        begin
            d.exp = 5'd1;
            d.sig = {1'b0, h[9:0]};
            d.cls = (h[9:0] == 10'd0) ? FP_ZERO : FP_NORM;
        end
        return d;
    endfunction

    function automatic logic [26:0] norm22(logic [21:0] v);
        logic [21:0] s;
        logic [4:0]  n;
        s = v;
        n = 5'd0;
        if (s[21:6] == 16'd0) begin s = s << 16; n = n + 5'd16; end
        if (s[21:14] == 8'd0) begin s = s << 8; n = n + 5'd8; end
        if (s[21:18] == 4'd0) begin s = s << 4; n = n + 5'd4; end
        if (s[21:20] == 2'd0) begin s = s << 2; n = n + 5'd2; end
        if (!s[21]) begin s = s << 1; n = n + 5'd1; end
        return {n, s};
    endfunction

    function automatic logic [31:0] norm27(logic [26:0] v);
        logic [26:0] s;
        logic [4:0]  n;
        s = v;
        n = 5'd0;
        if (s[26:11] == 16'd0) begin s = s << 16; n = n + 5'd16; end
        if (s[26:19] == 8'd0) begin s = s << 8; n = n + 5'd8; end
        if (s[26:23] == 4'd0) begin s = s << 4; n = n + 5'd4; end
        if (s[26:25] == 2'd0) begin s = s << 2; n = n + 5'd2; end
        if (!s[26]) begin s = s << 1; n = n + 5'd1; end
        return {n, s};
    endfunction

    function automatic logic [HALF_W-1:0] to_half(fp_class_t cls, logic s, logic [7:0] e,
                                                  logic [23:0] man);
        logic signed [9:0] ee;
        logic [4:0]  sh;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] hw;
        logic [14:0] qn;
        logic [12:0] rm;
        logic [HALF_W-1:0] r;
        ee = $signed({2'b00, e}) - 10'sd112;
        r  = {s, 15'd0};
        case (cls)
            FP_NAN:  r = HALF_QNAN;
            FP_INF:  r = {s, HALF_INF[14:0]};
            FP_ZERO: r = {s, 15'd0};
            default:
            begin
                if (ee >= 10'sd31)
                    r = {s, HALF_INF[14:0]};
                else if (ee <= 10'sd0)
                begin
                    if (ee >= -10'sd10)
                    begin
                        sh  = 5'(10'sd14 - ee);
                        q   = man >> sh;
                        rem = man & ((24'd1 << sh) - 24'd1);
                        hw  = 24'd1 << (sh - 5'd1);
                        if ((rem > hw) || ((rem == hw) && q[0]))
                            q = q + 24'd1;
                        r = {s, q[14:0]};
                    end
                end
                else
                begin
                    qn = {ee[4:0], man[22:13]};
                    rm = man[12:0];
                    if ((rm > 13'h1000) || ((rm == 13'h1000) && qn[0]))
                        qn = qn + 15'd1;
                    r = {s, qn};
                end
            end
        endcase
        return r;
    endfunction

    // Stores
    logic [HALF_W-1:0] weight_mem [WDEPTH];
    logic [HALF_W-1:0] bias_mem   [MAX_OUT_CH];
    logic [HALF_W-1:0] pixel_mem  [PDEPTH];
    logic [HALF_W-1:0] w_rd_reg;
    logic [HALF_W-1:0] b_rd_reg;
    logic [HALF_W-1:0] p_rd_reg;

    bstate_t state_reg, state_next;
    logic              out_valid_reg;
    logic [HALF_W-1:0] out_value_reg;
    logic              out_err_reg;
    logic              out_free;

    // Loop position
    logic [CHAN_W-1:0] oc_reg;
    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  col_reg;
    logic [ICH_W-1:0]  c_reg, c_next;
    logic [1:0]        kh_reg, kh_next;
    logic [1:0]        kw_reg, kw_next;
    logic              init_reg;

    // Product and accumulator
    logic              p_sign_reg;
    fp_class_t         p_cls_reg;
    logic [21:0]       p_sig_reg;
    logic [5:0]        p_esum_reg;
    logic [7:0]        pe_reg;
    logic [23:0]       pm_reg;
    logic              acc_sign_reg;
    fp_class_t         acc_cls_reg;
    logic [7:0]        acc_exp_reg;
    logic [23:0]       acc_man_reg;

    // Adder pipeline
    logic              big_sign_reg;
    logic [7:0]        big_exp_reg;
    logic [26:0]       big_m_reg;
    logic [26:0]       al_reg;
    logic              sub_reg;
    logic [27:0]       sum_reg;
    logic [26:0]       n_reg;
    logic [8:0]        ne_reg;
    logic              nz_reg;

    logic              do_pop;
    logic              done;
    logic [7:0]        ih_ext, iw_ext, ih, iw;
    logic              inb;
    logic [WAW-1:0]    w_wr_addr, w_rd_addr;
    logic [PAW-1:0]    p_wr_addr, p_rd_addr;
    logic              rd_en;
    half_dec_t         da, db;
    logic [26:0]       pn;
    logic [31:0]       sn;
    logic              byp;
    fp_class_t         byp_cls;
    logic              byp_sign;
    logic [7:0]        byp_exp;
    logic [23:0]       byp_man;
    logic              a_big;
    logic [7:0]        dexp;
    logic [26:0]       small_ext;
    logic [26:0]       al_shift;
    logic [26:0]       al_val;
    logic [23:0]       r_m24;
    logic [24:0]       r_m25;
    logic              r_up;
    logic [8:0]        r_e9;

    assign out_free = !out_valid_reg || result.ready;
    assign do_pop   = (state_reg == B_IDLE) && !q_stat.empty &&
                      !((head.kind == KIND_RANGE_ERR) && !out_free);
    assign pop      = do_pop;

    assign done   = (c_reg == sizes.nic);
    assign ih_ext = 8'(row_reg) + 8'(kh_reg);
    assign iw_ext = 8'(col_reg) + 8'(kw_reg);
    assign ih     = ih_ext - 8'(PAD);
    assign iw     = iw_ext - 8'(PAD);
    assign inb    = (ih_ext >= 8'(PAD)) && (ih < 8'(sizes.nh)) &&
                    (iw_ext >= 8'(PAD)) && (iw < 8'(sizes.nw));
    assign rd_en  = (state_reg == B_ADDR) && !done && inb;

    assign w_wr_addr = WAW'((32'(head.out_chan) * MAX_IN_CH + 32'(head.in_chan)) * TAPS
                            + 32'(head.tap));
    assign p_wr_addr = PAW'((32'(head.in_chan) * MAX_ROWS + 32'(head.row_index)) * MAX_COLS
                            + 32'(head.col_index));
    assign w_rd_addr = WAW'((32'(oc_reg) * MAX_IN_CH + 32'(c_reg)) * TAPS
                            + 32'(kh_reg) * KSIZE + 32'(kw_reg));
    assign p_rd_addr = PAW'((32'(c_reg) * MAX_ROWS + 32'(ih)) * MAX_COLS + 32'(iw));

    always_ff @(posedge clk)
    begin
        if (do_pop && (head.kind == KIND_WR_WEIGHT))
            weight_mem[w_wr_addr] <= head.data_word;
        if (rd_en)
            w_rd_reg <= weight_mem[w_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && (head.kind == KIND_WR_BIAS))
            bias_mem[BAW'(head.out_chan)] <= head.data_word;
        if (state_reg == B_BIAS)
            b_rd_reg <= bias_mem[BAW'(oc_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && (head.kind == KIND_WR_PIXEL))
            pixel_mem[p_wr_addr] <= head.data_word;
        if (rd_en)
            p_rd_reg <= pixel_mem[p_rd_addr];
    end

    // Next kernel position in input-channel, kernel-row, kernel-column order.
    always_comb
    begin
        c_next  = c_reg;
        kh_next = kh_reg;
        kw_next = kw_reg + 2'd1;
        if (kw_reg == 2'(KSIZE - 1))
        begin
            kw_next = 2'd0;
            kh_next = kh_reg + 2'd1;
            if (kh_reg == 2'(KSIZE - 1))
            begin
                kh_next = 2'd0;
                c_next  = c_reg + 1'b1;
            end
        end
    end

    // Product operands: the bias enters as bias times one.
    assign da = half_decode(init_reg ? b_rd_reg : p_rd_reg);
    assign db = half_decode(init_reg ? HALF_ONE : w_rd_reg);
    assign pn = norm22(p_sig_reg);

    // Special operands bypass the adder.
    always_comb
    begin
        byp      = init_reg || (acc_cls_reg != FP_NORM) || (p_cls_reg != FP_NORM);
        byp_cls  = acc_cls_reg;
        byp_sign = acc_sign_reg;
        byp_exp  = acc_exp_reg;
        byp_man  = acc_man_reg;
        if (init_reg || ((acc_cls_reg == FP_ZERO) && (p_cls_reg != FP_ZERO)) ||
            ((p_cls_reg == FP_INF) && (acc_cls_reg != FP_INF)))
        begin
            byp_cls  = p_cls_reg;
            byp_sign = p_sign_reg;
            byp_exp  = pe_reg;
            byp_man  = pm_reg;
        end
        if (!init_reg)
        begin
            if ((acc_cls_reg == FP_NAN) || (p_cls_reg == FP_NAN) ||
                ((acc_cls_reg == FP_INF) && (p_cls_reg == FP_INF) &&
                 (acc_sign_reg != p_sign_reg)))
                byp_cls = FP_NAN;
            else if ((acc_cls_reg == FP_ZERO) && (p_cls_reg == FP_ZERO))
                byp_sign = acc_sign_reg & p_sign_reg;
        end
    end

    // Alignment of the smaller operand with guard, round and sticky bits.
    always_comb
    begin
        a_big     = {acc_exp_reg, acc_man_reg} >= {pe_reg, pm_reg};
        dexp      = a_big ? (acc_exp_reg - pe_reg) : (pe_reg - acc_exp_reg);
        small_ext = a_big ? {pm_reg, 3'b000} : {acc_man_reg, 3'b000};
        al_shift  = small_ext >> dexp;
        if (dexp >= 8'd27)
            al_val = 27'd1;
        else
            al_val = {al_shift[26:1],
                      al_shift[0] | ((small_ext & ((27'd1 << dexp) - 27'd1)) != 27'd0)};
    end

    assign sn = norm27(sum_reg[26:0]);

    always_comb
    begin
        r_m24 = n_reg[26:3];
        r_up  = n_reg[2] && ((n_reg[1:0] != 2'd0) || r_m24[0]);
        r_m25 = {1'b0, r_m24} + 25'(r_up);
        r_e9  = ne_reg + 9'(r_m25[24]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (do_pop && (head.kind == KIND_COMPUTE))
                    state_next = B_BIAS;
            B_BIAS:
                state_next = sizes.bias_en ? B_MUL : B_ADDR;
            B_ADDR:
                if (done)
                    state_next = B_FINAL;
                else if (inb)
                    state_next = B_MUL;
            B_MUL:   state_next = B_PNORM;
            B_PNORM: state_next = B_ALIGN;
            B_ALIGN: state_next = byp ? B_ADDR : B_ADD;
            B_ADD:   state_next = B_NORM;
            B_NORM:  state_next = B_ROUND;
            B_ROUND: state_next = B_ADDR;
            B_FINAL:
                if (out_free)
                    state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_pop && (head.kind == KIND_RANGE_ERR))
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= '0;
                out_err_reg   <= 1'b1;
            end
            else if ((state_reg == B_FINAL) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= to_half(acc_cls_reg, acc_sign_reg, acc_exp_reg, acc_man_reg);
                out_err_reg   <= 1'b0;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
                if (do_pop)
                begin
                    oc_reg       <= head.out_chan;
                    row_reg      <= head.row_index;
                    col_reg      <= head.col_index;
                    c_reg        <= '0;
                    kh_reg       <= 2'd0;
                    kw_reg       <= 2'd0;
                    init_reg     <= 1'b0;
                    acc_cls_reg  <= FP_ZERO;
                    acc_sign_reg <= 1'b0;
                end
            B_BIAS:
                init_reg <= sizes.bias_en;
            B_ADDR:
                if (!done && !inb)
                begin
                    c_reg  <= c_next;
                    kh_reg <= kh_next;
                    kw_reg <= kw_next;
                end
            B_MUL:
            begin
                p_sign_reg <= da.sign ^ db.sign;
                p_sig_reg  <= da.sig * db.sig;
                p_esum_reg <= 6'(da.exp) + 6'(db.exp);
                if ((da.cls == FP_NAN) || (db.cls == FP_NAN) ||
                    ((da.cls == FP_INF) && (db.cls == FP_ZERO)) ||
                    ((da.cls == FP_ZERO) && (db.cls == FP_INF)))
                    p_cls_reg <= FP_NAN;
                else if ((da.cls == FP_INF) || (db.cls == FP_INF))
                    p_cls_reg <= FP_INF;
                else if ((da.cls == FP_ZERO) || (db.cls == FP_ZERO))
                    p_cls_reg <= FP_ZERO;
                else
                    p_cls_reg <= FP_NORM;
            end
            B_PNORM:
            begin
                pm_reg <= {pn[21:0], 2'b00};
                pe_reg <= 8'(9'(p_esum_reg) + 9'(PROD_EXP_OFFSET) - 9'(pn[26:22]));
            end
            B_ALIGN:
            begin
                if (byp)
                begin
                    acc_cls_reg  <= byp_cls;
                    acc_sign_reg <= byp_sign;
                    acc_exp_reg  <= byp_exp;
                    acc_man_reg  <= byp_man;
                    init_reg     <= 1'b0;
                    if (!init_reg)
                    begin
                        c_reg  <= c_next;
                        kh_reg <= kh_next;
                        kw_reg <= kw_next;
                    end
                end
                big_sign_reg <= a_big ? acc_sign_reg : p_sign_reg;
                big_exp_reg  <= a_big ? acc_exp_reg : pe_reg;
                big_m_reg    <= a_big ? {acc_man_reg, 3'b000} : {pm_reg, 3'b000};
                al_reg       <= al_val;
                sub_reg      <= acc_sign_reg ^ p_sign_reg;
            end
            B_ADD:
                sum_reg <= sub_reg ? ({1'b0, big_m_reg} - {1'b0, al_reg})
                                   : ({1'b0, big_m_reg} + {1'b0, al_reg});
            B_NORM:
            begin
                nz_reg <= (sum_reg == 28'd0);
                if (sum_reg[27])
                begin
                    n_reg  <= {sum_reg[27:2], sum_reg[1] | sum_reg[0]};
                    ne_reg <= {1'b0, big_exp_reg} + 9'd1;
                end
                else
                begin
                    n_reg  <= sn[26:0];
                    ne_reg <= {1'b0, big_exp_reg} - 9'(sn[31:27]);
                end
            end
            B_ROUND:
            begin
                c_reg  <= c_next;
                kh_reg <= kh_next;
                kw_reg <= kw_next;
                if (nz_reg)
                begin
                    acc_cls_reg  <= FP_ZERO;
                    acc_sign_reg <= 1'b0;
                end
                else
                begin
                    acc_sign_reg <= big_sign_reg;
                    acc_exp_reg  <= r_e9[7:0];
                    acc_man_reg  <= r_m25[24] ? r_m25[24:1] : r_m25[23:0];
                    acc_cls_reg  <= (r_e9 >= 9'd255) ? FP_INF : FP_NORM;
                end
            end
            default: ;
        endcase
    end

    assign result.valid       = out_valid_reg;
    assign result.out_value   = out_value_reg;
    assign result.range_error = out_err_reg;

endmodule
